// ===== hw/rtl/qvr_pkg.sv =====
// ---------------------------------------------------------------------------
// qvr_pkg
// Shared constants and helpers for the quaternion vector rotate core.
// ---------------------------------------------------------------------------
`default_nettype none
package qvr_pkg;
   localparam int CORDIC_STEPS = 23;
   localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
   localparam logic signed [27:0] DEG_90  = 28'sd5898240;
   localparam logic signed [27:0] DEG_180 = 28'sd11796480;
   localparam logic signed [27:0] DEG_360 = 28'sd23592960;

   function automatic logic signed [27:0] atan_deg(input int i);
      logic signed [27:0] t;
      case (i)
         0: t = 28'sd2949120;   1: t = 28'sd1740967;  2: t = 28'sd919879;
         3: t = 28'sd466945;    4: t = 28'sd234379;   5: t = 28'sd117304;
         6: t = 28'sd58666;     7: t = 28'sd29335;    8: t = 28'sd14668;
         9: t = 28'sd7334;     10: t = 28'sd3667;    11: t = 28'sd1833;
         12: t = 28'sd917;     13: t = 28'sd458;     14: t = 28'sd229;
         15: t = 28'sd115;     16: t = 28'sd57;      17: t = 28'sd29;
         18: t = 28'sd14;      19: t = 28'sd7;       20: t = 28'sd4;
         21: t = 28'sd2;       22: t = 28'sd1;
         default: t = 28'sd0;
      endcase
      return t;
   endfunction

   // clamp a wide value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sh0007fffffff) r = 32'sh7fffffff;
      else if (v < -68'sh00080000000) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic is_sat(input logic signed [67:0] v);
      return (v > 68'sh0007fffffff) || (v < -68'sh00080000000);
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/quaternion_vector_rotate_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_vector_rotate_core
// Rotates a vector by the unnormalized quaternion built from angle and axis.
// ---------------------------------------------------------------------------
// pipeline: 25 cordic stages + 2 quaternion stages + 2 + 2 product stages + 1
// output register between start and rsp_valid
// throughput: one item per cycle; busy stays low, the receiver cannot stall
// reset clears every valid bit; payload registers are not reset
`default_nettype none
module quaternion_vector_rotate_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [25:0] req_angle_deg,
   input  wire logic signed [31:0] req_axis_x,
   input  wire logic signed [31:0] req_axis_y,
   input  wire logic signed [31:0] req_axis_z,
   input  wire logic signed [31:0] req_vec_x,
   input  wire logic signed [31:0] req_vec_y,
   input  wire logic signed [31:0] req_vec_z,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_rot_x,
   output logic signed [31:0]      rsp_rot_y,
   output logic signed [31:0]      rsp_rot_z,
   output logic                    rsp_overflow
);
   import qvr_pkg::*;
   localparam int DLY = CORDIC_STEPS + 2;
   localparam int DOWN = 30 - FRAC_BITS;

   logic               c_valid;
   logic signed [35:0] c_sin, c_cos;
   logic signed [31:0] ax_ff [0:DLY-1][0:2];
   logic signed [31:0] vx_ff [0:DLY-1][0:2];
   logic signed [67:0] pr_ff [0:2];
   logic signed [35:0] cos_ff;
   logic signed [31:0] v2_ff [0:2];
   logic               qv_ff, qv2_ff, qovf_ff;
   logic signed [31:0] q_ff [0:3];
   logic signed [31:0] vq_ff [0:3];
   logic signed [67:0] rs [0:3];
   logic signed [31:0] va [0:3];
   logic signed [31:0] zero4 [0:3];
   logic               m1_valid, m1_ovf, m2_valid, m2_ovf;
   logic signed [31:0] t [0:3], q1 [0:3], rr [0:3], unused [0:3];
   logic               rsp_valid_ff, rsp_ovf_ff;
   logic signed [31:0] rot_ff [0:2];

   assign busy = 1'b0;

   qvr_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock(clock), .reset(reset), .in_valid(start), .in_angle(req_angle_deg),
      .out_valid(c_valid), .out_sin(c_sin), .out_cos(c_cos)
   );

   // axis and vector ride alongside the cordic
   always_ff @(posedge clock) begin
      ax_ff[0] <= '{req_axis_x, req_axis_y, req_axis_z};
      vx_ff[0] <= '{req_vec_x, req_vec_y, req_vec_z};
      for (int i = 1; i < DLY; i++) begin
         ax_ff[i] <= ax_ff[i-1];
         vx_ff[i] <= vx_ff[i-1];
      end
   end

   // quaternion build: multiply, then round and saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= 1'b0; qv2_ff <= 1'b0;
      end else begin
         qv_ff <= c_valid; qv2_ff <= qv_ff;
      end
      for (int i = 0; i < 3; i++) pr_ff[i] <= 68'(ax_ff[DLY-1][i]) * 68'(c_sin);
      cos_ff <= c_cos;
      v2_ff <= vx_ff[DLY-1];
      for (int i = 0; i < 4; i++) q_ff[i] <= sat32(rs[i]);
      qovf_ff <= is_sat(rs[0]) | is_sat(rs[1]) | is_sat(rs[2]) | is_sat(rs[3]);
      vq_ff <= va;
   end

   always_comb begin
      if (DOWN == 0) rs[0] = 68'(cos_ff);
      else rs[0] = (68'(cos_ff) + (68'sd1 <<< (DOWN - 1))) >>> DOWN;
      for (int i = 0; i < 3; i++)
         rs[i+1] = (pr_ff[i] + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      va = '{32'sd0, v2_ff[0], v2_ff[1], v2_ff[2]};
      zero4 = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
   end

   qvr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_qv (
      .clock(clock), .reset(reset), .in_valid(qv2_ff), .in_ovf(qovf_ff),
      .in_conj(1'b0), .in_a(q_ff), .in_b(vq_ff), .in_pass(q_ff),
      .out_valid(m1_valid), .out_ovf(m1_ovf), .out_p(t), .out_pass(q1)
   );

   qvr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_tq (
      .clock(clock), .reset(reset), .in_valid(m1_valid), .in_ovf(m1_ovf),
      .in_conj(1'b1), .in_a(t), .in_b(q1), .in_pass(zero4),
      .out_valid(m2_valid), .out_ovf(m2_ovf), .out_p(rr), .out_pass(unused)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= m2_valid;
      rsp_ovf_ff <= m2_ovf | (unused[0] != 32'sd0);
      rot_ff <= '{rr[1], rr[2], rr[3]};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rot_x = rot_ff[0];
   assign rsp_rot_y = rot_ff[1];
   assign rsp_rot_z = rot_ff[2];
   assign rsp_overflow = rsp_ovf_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/qvr_cordic.sv =====
// ---------------------------------------------------------------------------
// qvr_cordic
// Pipelined half-angle reduction and 23-step rotation CORDIC, one stage
// per iteration; gives sin and cos of half the angle in Q30.
// ---------------------------------------------------------------------------
`default_nettype none
module qvr_cordic #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [25:0] in_angle,
   output logic                    out_valid,
   output logic signed [35:0]      out_sin,
   output logic signed [35:0]      out_cos
);
   import qvr_pkg::*;
   localparam int N = CORDIC_STEPS;
   localparam int UP = (FRAC_BITS <= 15) ? 15 - FRAC_BITS : 0;
   localparam int DN = (FRAC_BITS > 15) ? FRAC_BITS - 15 : 0;
   // 2^48 / 360 degrees in Q16, so the product shifted by 48 is the turn count
   localparam logic signed [25:0] RECIP = 26'sd11930465;

   logic               v_ff  [0:N];
   logic               neg_ff[0:N];
   logic signed [35:0] x_ff  [0:N];
   logic signed [35:0] y_ff  [0:N];
   logic signed [27:0] r_ff  [0:N];
   logic               pv_ff;
   logic signed [33:0] h_in, h_ff;
   logic signed [59:0] p_in;
   logic signed [10:0] q_in, q_ff;
   logic signed [35:0] w;
   logic signed [27:0] r_in, m;
   logic               neg_in;

   // half angle in Q16 degrees and its whole number of turns
   always_comb begin
      h_in = (34'(in_angle) <<< UP) >>> DN;
      p_in = 60'(h_in) * 60'(RECIP);
      q_in = 11'(p_in >>> 48);
   end

   // remainder into -180..180, then folded into +-90 with sign flag
   always_comb begin
      w = 36'(h_ff) - 36'(q_ff) * 36'(DEG_360);
      if (w >= 36'(DEG_360)) w = w - 36'(DEG_360);
      if (w < 36'sd0) w = w + 36'(DEG_360);
      if (w >= 36'(DEG_180)) w = w - 36'(DEG_360);
      m = 28'(w);
      neg_in = 1'b0;
      r_in = m;
      if (m > DEG_90) begin
         r_in = m - DEG_180; neg_in = 1'b1;
      end else if (m < -DEG_90) begin
         r_in = m + DEG_180; neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else pv_ff <= in_valid;
      h_ff <= h_in;
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= pv_ff;
      x_ff[0] <= GAIN_Q30;
      y_ff[0] <= '0;
      r_ff[0] <= r_in;
      neg_ff[0] <= neg_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         if (r_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            r_ff[i+1] <= r_ff[i] - atan_deg(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            r_ff[i+1] <= r_ff[i] + atan_deg(i);
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_sin = neg_ff[N] ? -y_ff[N] : y_ff[N];
   assign out_cos = neg_ff[N] ? -x_ff[N] : x_ff[N];
endmodule
`default_nettype wire

// ===== hw/rtl/qvr_qmul.sv =====
// ---------------------------------------------------------------------------
// qvr_qmul
// Two-stage quaternion product: sixteen rounded 32x32 products, then
// four saturated sums. in_conj selects a*conj(b) for the second product.
// ---------------------------------------------------------------------------
`default_nettype none
module qvr_qmul #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic               in_ovf,
   input  wire logic               in_conj,
   input  wire logic signed [31:0] in_a [0:3],
   input  wire logic signed [31:0] in_b [0:3],
   input  wire logic signed [31:0] in_pass [0:3],
   output logic                    out_valid,
   output logic                    out_ovf,
   output logic signed [31:0]      out_p [0:3],
   output logic signed [31:0]      out_pass [0:3]
);
   import qvr_pkg::*;
   // index order: 0 = w, 1 = x, 2 = y, 3 = z
   logic               v_ff [0:1];
   logic               ovf_ff [0:1];
   logic signed [31:0] pass_ff [0:1][0:3];
   logic signed [63:0] m_ff [0:3][0:3];
   logic signed [31:0] p_ff [0:3];
   logic signed [63:0] r [0:3][0:3];
   logic signed [67:0] s [0:3];
   logic [3:0]         sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0; v_ff[1] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid; v_ff[1] <= v_ff[0];
      end
      ovf_ff[0] <= in_ovf;
      ovf_ff[1] <= ovf_ff[0] | (|sat);
      pass_ff[0] <= in_pass;
      pass_ff[1] <= pass_ff[0];
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            m_ff[i][j] <= 64'(in_a[i]) * 64'(in_b[j]);
      for (int i = 0; i < 4; i++) p_ff[i] <= sat32(s[i]);
   end

   always_comb begin
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            r[i][j] = (m_ff[i][j] + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (!in_conj) begin
         // t = a*b with a.w = q.w style, b pure vector (b.w = 0)
         s[0] = -68'(r[1][1]) - 68'(r[2][2]) - 68'(r[3][3]);
         s[1] = 68'(r[0][1]) + 68'(r[2][3]) - 68'(r[3][2]);
         s[2] = 68'(r[0][2]) + 68'(r[3][1]) - 68'(r[1][3]);
         s[3] = 68'(r[0][3]) + 68'(r[1][2]) - 68'(r[2][1]);
      end else begin
         // a = t, b = q; vector part of t*conj(q)
         s[0] = '0;
         s[1] = 68'(r[1][0]) - 68'(r[0][1]) - 68'(r[2][3]) + 68'(r[3][2]);
         s[2] = 68'(r[2][0]) - 68'(r[0][2]) - 68'(r[3][1]) + 68'(r[1][3]);
         s[3] = 68'(r[3][0]) - 68'(r[0][3]) - 68'(r[1][2]) + 68'(r[2][1]);
      end
      for (int i = 0; i < 4; i++) sat[i] = is_sat(s[i]);
   end

   assign out_valid = v_ff[1];
   assign out_ovf = ovf_ff[1];
   assign out_p = p_ff;
   assign out_pass = pass_ff[1];
endmodule
`default_nettype wire
